>>> design/lkc_pkg.sv
// lkc_pkg: shared types and constants for the keyed lru cache
// request and response structs, kind codes, controller states
// no dependencies
`default_nettype none

package lkc_pkg;

	localparam int ENTRIES_DEF     = 8;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int KEY_W           = 64;
	localparam int STAMP_W         = 64;
	localparam int FIELD_VAL_W     = 32;
	localparam int COUNT_W         = 4;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_GET   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]             kind;
		logic [KEY_W-1:0]       key_high;
		logic [KEY_W-1:0]       key_low;
		logic [FIELD_VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                   status;
		logic                   hit;
		logic [FIELD_VAL_W-1:0] value_out;
		logic [COUNT_W-1:0]     count;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> design/lru_keyed_cache_core.sv
// lru_keyed_cache_core: fully associative key/value cache with lru replacement
// slot keys, values and stamps sit in one synchronous memory, valid bits in flops
// depends on lkc_pkg
//
//   channel  direction  payload        handshake
//   req      in         lkc_pkg::req_t req_valid / req_stall
//   rsp      out        lkc_pkg::rsp_t rsp_valid / rsp_stall
//
// put and get scan all slots: one memory read per slot through the single
// read port, a compare on each registered read, then the update and result states
// clear, rejected put and the unused kind skip the scan and go to update, then result
// reset clears valid bits, count and use counter at once; no clearing pass
// a result waiting under rsp_stall does not block the next request
`default_nettype none

module lru_keyed_cache_core #(
	parameter int ENTRIES     = lkc_pkg::ENTRIES_DEF,
	parameter int VALUE_WIDTH = lkc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lkc_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lkc_pkg::rsp_t      rsp
);

	import lkc_pkg::*;

	localparam int AW       = $clog2(ENTRIES);
	localparam int CW       = $clog2(ENTRIES + 1);
	localparam int EW       = 2 * KEY_W + VALUE_WIDTH + STAMP_W;
	localparam int VAL_OFF  = STAMP_W;
	localparam int KL_OFF   = STAMP_W + VALUE_WIDTH;
	localparam int KH_OFF   = STAMP_W + VALUE_WIDTH + KEY_W;
	localparam int VAL_KEEP = (VALUE_WIDTH < FIELD_VAL_W) ? VALUE_WIDTH : FIELD_VAL_W;
	localparam logic [FIELD_VAL_W-1:0] VAL_MASK =
		FIELD_VAL_W'((65'd1 << VAL_KEEP) - 65'd1);

	state_t state_q, state_d;
	req_t   req_q;

	logic [EW-1:0] mem [ENTRIES];
	logic [EW-1:0] rd_data_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [AW:0]   scan_idx_q;
	logic          scan_issue;
	logic          scan_last;

	logic                   found_q;
	logic [AW-1:0]          match_idx_q;
	logic [VALUE_WIDTH-1:0] match_val_q;
	logic                   free_q;
	logic [AW-1:0]          victim_q;
	logic [STAMP_W-1:0]     best_q;

	logic [ENTRIES-1:0] valid_q, valid_d;
	logic [CW-1:0]      count_q, count_d;
	logic [STAMP_W-1:0] use_ctr_q, use_ctr_d;

	logic               mem_we;
	logic [AW-1:0]      wr_idx;
	logic [EW-1:0]      wr_data;
	rsp_t               res_q, res_d;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               accept;
	logic               load_rsp;
	logic [FIELD_VAL_W-1:0] val_m;
	logic [KEY_W-1:0]   rd_kh, rd_kl;
	logic [STAMP_W-1:0] rd_stamp;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic               rd_hit;
	logic [STAMP_W-1:0] ctr_inc;
	logic [CW+COUNT_W-1:0] count_ext;

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign load_rsp   = (state_q == S_RESULT) && (!rsp_valid_q || !rsp_stall);

	assign scan_issue = (state_q == S_SCAN) && (scan_idx_q < (AW + 1)'(ENTRIES));
	assign scan_last  = rd_vld_s1 && (rd_idx_s1 == AW'(ENTRIES - 1));

	assign rd_kh    = rd_data_s1[KH_OFF +: KEY_W];
	assign rd_kl    = rd_data_s1[KL_OFF +: KEY_W];
	assign rd_val   = rd_data_s1[VAL_OFF +: VALUE_WIDTH];
	assign rd_stamp = rd_data_s1[STAMP_W-1:0];
	assign rd_hit   = rd_vld_s1 && valid_q[rd_idx_s1] &&
		(rd_kh == req_q.key_high) && (rd_kl == req_q.key_low);

	assign val_m   = req_q.value & VAL_MASK;
	assign ctr_inc = use_ctr_q + STAMP_W'(1);

	// slot memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_data;
		end
		rd_data_s1 <= mem[scan_idx_q[AW-1:0]];
		rd_idx_s1  <= scan_idx_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_vld_s1   <= 1'b0;
			scan_idx_q  <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			use_ctr_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (scan_issue) begin
				scan_idx_q <= scan_idx_q + (AW + 1)'(1);
			end
			if (state_q == S_UPDATE) begin
				valid_q   <= valid_d;
				count_q   <= count_d;
				use_ctr_q <= use_ctr_d;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, scan results, result and response registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			victim_q <= '0;
			best_q  <= '1;
		end else if (rd_vld_s1) begin
			if (rd_hit && !found_q) begin
				found_q     <= 1'b1;
				match_idx_q <= rd_idx_s1;
				match_val_q <= rd_val;
			end
			if (!valid_q[rd_idx_s1]) begin
				free_q   <= 1'b1;
				victim_q <= rd_idx_s1;
				best_q   <= '0;
			end else if (rd_stamp < best_q) begin
				best_q   <= rd_stamp;
				victim_q <= rd_idx_s1;
			end
		end
		if (state_q == S_UPDATE) begin
			res_q <= res_d;
		end
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		valid_d   = valid_q;
		count_d   = count_q;
		use_ctr_d = use_ctr_q;
		mem_we    = 1'b0;
		wr_idx    = found_q ? match_idx_q : victim_q;
		wr_data   = {req_q.key_high, req_q.key_low, VALUE_WIDTH'(val_m), ctr_inc};
		res_d     = '0;
		count_ext = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((req.kind == KIND_GET) ||
					    ((req.kind == KIND_PUT) && ((req.value & VAL_MASK) != '0))) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_UPDATE;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				case (req_q.kind)
					KIND_PUT: begin
						if (val_m == '0) begin
							res_d.status = 1'b1;
						end else begin
							mem_we    = 1'b1;
							use_ctr_d = ctr_inc;
							if (!found_q) begin
								valid_d[victim_q] = 1'b1;
								if (free_q) begin
									count_d = count_q + CW'(1);
								end
							end
						end
					end
					KIND_GET: begin
						if (found_q) begin
							mem_we    = 1'b1;
							use_ctr_d = ctr_inc;
							wr_data   = {req_q.key_high, req_q.key_low, match_val_q, ctr_inc};
							res_d.hit = 1'b1;
							res_d.value_out = FIELD_VAL_W'(match_val_q);
						end
					end
					KIND_CLEAR: begin
						valid_d   = '0;
						count_d   = '0;
						use_ctr_d = '0;
					end
					default: begin
					end
				endcase
				count_ext   = (CW + COUNT_W)'(count_d);
				res_d.count = count_ext[COUNT_W-1:0];
				state_d     = S_RESULT;
			end
			S_RESULT: begin
				if (load_rsp) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_q)))
		else $error("valid count out of step with valid bits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("valid count beyond slot total");

	a_match_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) && (req_q.kind == KIND_GET) && found_q |->
		valid_q[match_idx_q])
		else $error("get hit on an invalid slot");

	a_update_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |=> (state_q == S_RESULT))
		else $error("update not followed by result");

	a_scan_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("slot read data outside of scan");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for lru_keyed_cache_core, directed then random put/get/clear/unused traffic
// a mirror of the lru cache predicts every response; the request side idles and the response side stalls at random
// depends on lkc_pkg and lru_keyed_cache_core
module tb_top;
	import lkc_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam int POOL = 12;
	localparam int RANDOM_ITEMS = 1880;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 500;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class lru_cache_mirror;
		logic [KEY_W-1:0]       key_hi[SLOTS];
		logic [KEY_W-1:0]       key_lo[SLOTS];
		logic [FIELD_VAL_W-1:0] data[SLOTS];
		logic [STAMP_W-1:0]     stamp[SLOTS];
		bit                     live[SLOTS];
		logic [STAMP_W-1:0]     use_ctr;
		rsp_t                   pending_rsp_q[$];
		int                     errors;
		int                     requests;

		function void wipe();
			foreach (live[i]) begin
				key_hi[i] = '0;
				key_lo[i] = '0;
				data[i] = '0;
				stamp[i] = '0;
				live[i] = 1'b0;
			end
			use_ctr = '0;
		endfunction

		function int find_slot(req_t r);
			foreach (live[i])
				if (live[i] && key_hi[i] == r.key_high && key_lo[i] == r.key_low)
					return i;
			return -1;
		endfunction

		function void apply_request(req_t r);
			rsp_t e;
			int m;
			logic [STAMP_W-1:0] best;
			e = '0;
			requests++;
			case (r.kind)
			KIND_PUT: begin
				if (r.value == '0) begin
					e.status = 1'b1;
				end else begin
					m = find_slot(r);
					if (m < 0) begin
						m = 0;
						best = '1;
						foreach (live[i]) begin
							if (!live[i]) begin
								m = i;
								best = '0;
							end else if (stamp[i] < best) begin
								best = stamp[i];
								m = i;
							end
						end
						key_hi[m] = r.key_high;
						key_lo[m] = r.key_low;
						live[m] = 1'b1;
					end
					data[m] = r.value;
					use_ctr++;
					stamp[m] = use_ctr;
				end
			end
			KIND_GET: begin
				m = find_slot(r);
				if (m >= 0) begin
					use_ctr++;
					stamp[m] = use_ctr;
					e.hit = 1'b1;
					e.value_out = data[m];
				end
			end
			KIND_CLEAR: begin
				wipe();
			end
			default: begin
			end
			endcase
			e.count = '0;
			foreach (live[i])
				e.count += COUNT_W'(live[i]);
			pending_rsp_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp_q.size() == 0) begin
				$error("response with no request outstanding: %p", got);
				errors++;
				return;
			end
			e = pending_rsp_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, got.status);
				errors++;
			end
			if (got.hit !== e.hit) begin
				$error("hit: expected %0d actual %0d", e.hit, got.hit);
				errors++;
			end
			if (got.value_out !== e.value_out) begin
				$error("value_out: expected %h actual %h", e.value_out, got.value_out);
				errors++;
			end
			if (got.count !== e.count) begin
				$error("count: expected %0d actual %0d", e.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic hold_rsp = 1'b0;
	bit tx_calm = 1'b0;
	logic [KEY_W-1:0] pool_hi[POOL];
	logic [KEY_W-1:0] pool_lo[POOL];
	lru_cache_mirror mirror = new;

	lru_keyed_cache_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t make_req(logic [1:0] kind, logic [KEY_W-1:0] kh,
			logic [KEY_W-1:0] kl, logic [FIELD_VAL_W-1:0] v);
		req_t r;
		r.kind = kind;
		r.key_high = kh;
		r.key_low = kl;
		r.value = v;
		return r;
	endfunction

	task automatic refill_key_pool();
		for (int i = 0; i < POOL; i++) begin
			pool_hi[i] = rand64();
			pool_lo[i] = rand64();
		end
		// short key padded with zeros, and pairs sharing one half
		pool_lo[0] = '0;
		pool_hi[1] = pool_hi[0];
		pool_lo[3] = pool_lo[2];
	endtask

	task automatic send_request(input req_t r);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		mirror.apply_request(r);
	endtask

	task automatic wait_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending_rsp_q.size() != 0) @(posedge clk);
	endtask

	// response side: random stall after each response, plus the long hold-off
	initial begin
		int stall_left;
		bit rx_calm;
		stall_left = 0;
		rx_calm = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				mirror.check_response(rsp);
				if ($urandom_range(0, 63) == 0)
					rx_calm = !rx_calm;
				stall_left = rx_calm ? 0 : $urandom_range(0, 17);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= hold_rsp || (stall_left > 0);
		end
	end

	initial begin
		do @(posedge clk); while (mirror.requests < HOLD_AFTER);
		hold_rsp <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	initial begin
		req_t r;
		int pick;
		int idx;
		refill_key_pool();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_req(KIND_GET, '1, '1, 32'h1));
		send_request(make_req(KIND_PUT, pool_hi[5], pool_lo[5], '0));
		send_request(make_req(KIND_PUT, '0, '0, 32'h1));
		send_request(make_req(KIND_PUT, '1, '1, '1));
		send_request(make_req(KIND_GET, '1, '1, '0));
		send_request(make_req(KIND_PUT, '1, '1, 32'h8000_0000));
		send_request(make_req(KIND_GET, '1, '1, '0));
		send_request(make_req(KIND_GET, '1, '0, '0));
		for (int i = 0; i < SLOTS - 2; i++)
			send_request(make_req(KIND_PUT, pool_hi[i], pool_lo[i], $urandom | 32'h1));
		// refresh the oldest entry so the all-ones key becomes lru
		send_request(make_req(KIND_GET, '0, '0, '1));
		send_request(make_req(KIND_PUT, pool_hi[6], pool_lo[6], 32'h5a5a_a5a5));
		send_request(make_req(KIND_GET, '1, '1, '0));
		send_request(make_req(KIND_UNUSED, pool_hi[6], pool_lo[6], '1));
		send_request(make_req(KIND_CLEAR, '1, '1, '1));
		send_request(make_req(KIND_GET, '0, '0, '0));
		send_request(make_req(KIND_PUT, pool_hi[7], pool_lo[7], 32'h0000_0002));
		wait_until_drained();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 300 == 299)
				refill_key_pool();
			if (k == RANDOM_ITEMS / 2)
				wait_until_drained();
			if ($urandom_range(0, 79) == 0)
				tx_calm = !tx_calm;
			pick = $urandom_range(0, 99);
			r.kind = pick < 50 ? KIND_PUT : pick < 96 ? KIND_GET :
				pick < 98 ? KIND_CLEAR : KIND_UNUSED;
			if ($urandom_range(0, 9) == 0) begin
				r.key_high = rand64();
				r.key_low = rand64();
			end else begin
				idx = $urandom_range(0, POOL - 1);
				r.key_high = pool_hi[idx];
				r.key_low = pool_lo[idx];
			end
			pick = $urandom_range(0, 19);
			r.value = pick == 0 ? '0 : pick == 1 ? '1 : $urandom;
			send_request(r);
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending_rsp_q.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> filelist.f
design/lkc_pkg.sv
design/lru_keyed_cache_core.sv
verif/tb_top.sv
